// ===== src/pkc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the permutation keystream cipher.
// Request/response payload types, opcodes, widths and sequencer control struct.
// No dependencies.
package pkc_pkg;

   localparam int STATE_BYTES_DEF = 64;
   localparam int PERM_DEPTH      = 64;
   localparam int PERM_AW         = 6;
   localparam int PASS_BYTES      = 32;
   localparam int PASS_AW         = 5;
   localparam int BLOCK_BYTES     = 8;
   localparam int BLOCK_AW        = 3;
   localparam int CSR_WORDS       = 4;
   localparam int CSR_WORD_AW     = 2;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_W           = 64;

   // pipeline depth after issue, mix and compose passes
   localparam int MIX_LAT  = 2;
   localparam int COMP_LAT = 3;

   localparam logic [1:0] OP_LOAD_KEY = 2'd0;
   localparam logic [1:0] OP_LOAD_X   = 2'd1;
   localparam logic [1:0] OP_LOAD_Y   = 2'd2;
   localparam logic [1:0] OP_BLOCK    = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  entry_index;
      logic [7:0]  entry_value;
      logic [63:0] data_block;
      logic [3:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_block;
      logic [3:0]  valid_bytes;
   } rsp_type;

   typedef logic [PASS_BYTES-1:0][7:0] pass_type;

   typedef struct packed {
      logic               mix_issue;
      logic               comp_issue;
      logic [PERM_AW-1:0] idx;
      logic               mix_end;
      logic               comp_end;
      logic               finish;
   } seq_type;

endpackage

// ===== src/pkc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pkc_seq.sv =====
`timescale 1ns / 1ps
// Sequencer for one block request: mix pass, compose pass, result hand-off.
// Depends on pkc_pkg.
module pkc_seq import pkc_pkg::*; #(
   parameter int STATE_BYTES = STATE_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    rsp_free,
   output logic    idle,
   output seq_type ctl
);

   localparam int CNT_W = $clog2(STATE_BYTES + COMP_LAT);
   localparam logic [CNT_W-1:0] ISSUE_LIM = CNT_W'(STATE_BYTES);
   localparam logic [CNT_W-1:0] MIX_LAST  = CNT_W'(STATE_BYTES - 1 + MIX_LAT);
   localparam logic [CNT_W-1:0] COMP_LAST = CNT_W'(STATE_BYTES - 1 + COMP_LAT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIX  = 2'd1;
   localparam logic [1:0] ST_COMP = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      ctl            = '0;
      ctl.idx        = cnt_ff[PERM_AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            ctl.mix_issue = (cnt_ff < ISSUE_LIM);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == MIX_LAST) begin
               ctl.mix_end = 1'b1;
               cnt_in      = '0;
               state_in    = ST_COMP;
            end
         end
         ST_COMP: begin
            ctl.comp_issue = (cnt_ff < ISSUE_LIM);
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == COMP_LAST) begin
               ctl.comp_end = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

// ===== src/permutation_keystream_cipher.sv =====
`timescale 1ns / 1ps
// Top level of the permutation keystream cipher: memories and mix/compose datapath.
// Depends on pkc_pkg, pkc_ram and pkc_seq.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+---------
//   request | req_valid / req_ready          | in        | req_type
//   result  | rsp_valid / rsp_ready          | out       | rsp_type
//   config  | csr_wr_en, csr_index, csr_wdata| in        | 64-bit word
//
// Loads are taken whenever the block is idle.
// A block request passes one state byte per cycle through the mix pipeline,
// then one permutation entry per cycle through the three chained table reads
// of the compose pipeline.
// Reset clears the state (valid bits), password and control; tables start undefined.
// A result held by rsp_ready low stalls only the end of the next block.
module permutation_keystream_cipher import pkc_pkg::*; #(
   parameter int STATE_BYTES = STATE_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int SIDX_W = $clog2(STATE_BYTES);
   localparam int SDEPTH = 1 << SIDX_W;
   localparam int SAW    = SIDX_W + 1;
   localparam int CMP_W  = PERM_AW + 1;
   localparam logic [CMP_W-1:0] SB_LIM    = CMP_W'(STATE_BYTES);
   localparam logic [CMP_W-1:0] PASS_LIM  = CMP_W'(PASS_BYTES);
   localparam logic [CMP_W-1:0] BLOCK_LIM = CMP_W'(BLOCK_BYTES);
   localparam logic [CSR_IDX_W-1:0] CSR_LIM = CSR_IDX_W'(CSR_WORDS);

   function automatic logic [7:0] pass_sel(input logic [PERM_AW-1:0] j, input pass_type p);
      if ({1'b0, j} < PASS_LIM) begin
         return p[j[PASS_AW-1:0]];
      end
      return 8'h00;
   endfunction

   // control
   seq_type ctl;
   logic    idle, req_fire, start, load_ok, key_load, x_load, y_load, rsp_free;

   // password
   logic [CSR_WORDS-1:0][CSR_W-1:0] pw_ff;
   pass_type                        pass_bytes;

   // bank selects and state valid bits
   logic              sbank_ff, sbank_in;
   logic              ybank_ff, ybank_in;
   logic [SDEPTH-1:0] valid_ff, valid_in;

   // request data of the block in flight
   logic [63:0]          data_ff;
   logic [3:0]           cnt_ff;
   logic [BLOCK_BYTES-1:0][7:0] ks_ff;

   // mix pipeline
   logic               m1_v_ff, m2_v_ff;
   logic [PERM_AW-1:0] m1_idx_ff, m2_idx_ff, m2_y_ff;
   logic               m2_okb_ff, m2_va_ff, m2_vb_ff;
   logic [7:0]         byte_a, byte_b, mix_byte;

   // compose pipeline
   logic               c1_v_ff, c2_v_ff, c3_v_ff;
   logic [PERM_AW-1:0] c1_idx_ff, c2_idx_ff, c3_idx_ff;

   // memory ports
   logic               st_we;
   logic [SAW-1:0]     st_waddr, st_raddr_a, st_raddr_b;
   logic [7:0]         st_wdata, st_rdata_a, st_rdata_b;
   logic               y_we;
   logic [PERM_AW:0]   y_waddr, y_raddr;
   logic [PERM_AW-1:0] y_wdata, y_rdata;
   logic               x_we;
   logic [PERM_AW-1:0] x_waddr, x_wdata, x_raddr, x_rdata;
   logic [PERM_AW-1:0] xi_waddr, xi_wdata, xi_raddr, xi_rdata;

   // result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   pkc_seq #(.STATE_BYTES(STATE_BYTES)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .rsp_free (rsp_free),
      .idle     (idle),
      .ctl      (ctl)
   );

   assign req_ready  = idle;
   assign req_fire   = req_valid & req_ready;
   assign start      = req_fire && (req_payload.opcode == OP_BLOCK);
   assign load_ok    = req_fire && ({1'b0, req_payload.entry_index} < SB_LIM);
   assign key_load   = load_ok && (req_payload.opcode == OP_LOAD_KEY);
   assign x_load     = load_ok && (req_payload.opcode == OP_LOAD_X);
   assign y_load     = load_ok && (req_payload.opcode == OP_LOAD_Y);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign pass_bytes = pw_ff;

   // state bytes: two copies so the mix pass can read two bytes per cycle
   always_comb begin
      if (key_load) begin
         st_we    = 1'b1;
         st_waddr = {sbank_ff, req_payload.entry_index[SIDX_W-1:0]};
         st_wdata = req_payload.entry_value;
      end else begin
         st_we    = m2_v_ff;
         st_waddr = {~sbank_ff, m2_idx_ff[SIDX_W-1:0]};
         st_wdata = mix_byte;
      end
   end

   assign st_raddr_a = {sbank_ff, m1_idx_ff[SIDX_W-1:0]};
   assign st_raddr_b = {sbank_ff, y_rdata[SIDX_W-1:0]};

   pkc_ram #(.WIDTH(8), .DEPTH(2 * SDEPTH)) u_state_a (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr_a),
      .rd_data (st_rdata_a)
   );

   pkc_ram #(.WIDTH(8), .DEPTH(2 * SDEPTH)) u_state_b (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr_b),
      .rd_data (st_rdata_b)
   );

   // inner permutation, two banks: compose writes the idle bank
   always_comb begin
      if (y_load) begin
         y_we    = 1'b1;
         y_waddr = {ybank_ff, req_payload.entry_index};
         y_wdata = req_payload.entry_value[PERM_AW-1:0];
      end else begin
         y_we    = c3_v_ff;
         y_waddr = {~ybank_ff, c3_idx_ff};
         y_wdata = x_rdata;
      end
      if (c1_v_ff) begin
         y_raddr = {ybank_ff, xi_rdata};
      end else begin
         y_raddr = {ybank_ff, ctl.idx};
      end
   end

   pkc_ram #(.WIDTH(PERM_AW), .DEPTH(2 * PERM_DEPTH)) u_inner (
      .clock   (clock),
      .wr_en   (y_we),
      .wr_addr (y_waddr),
      .wr_data (y_wdata),
      .rd_addr (y_raddr),
      .rd_data (y_rdata)
   );

   assign x_we     = x_load;
   assign x_waddr  = req_payload.entry_index;
   assign x_wdata  = req_payload.entry_value[PERM_AW-1:0];
   assign x_raddr  = y_rdata;
   assign xi_waddr = req_payload.entry_value[PERM_AW-1:0];
   assign xi_wdata = req_payload.entry_index;
   assign xi_raddr = ctl.idx;

   pkc_ram #(.WIDTH(PERM_AW), .DEPTH(PERM_DEPTH)) u_outer (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (x_waddr),
      .wr_data (x_wdata),
      .rd_addr (x_raddr),
      .rd_data (x_rdata)
   );

   pkc_ram #(.WIDTH(PERM_AW), .DEPTH(PERM_DEPTH)) u_outer_inv (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (xi_waddr),
      .wr_data (xi_wdata),
      .rd_addr (xi_raddr),
      .rd_data (xi_rdata)
   );

   // mix stage 2: old byte is stored byte (zero if never loaded) XOR password
   always_comb begin
      byte_a = (m2_va_ff ? st_rdata_a : 8'h00) ^ pass_sel(m2_idx_ff, pass_bytes);
      if (m2_okb_ff) begin
         byte_b = (m2_vb_ff ? st_rdata_b : 8'h00) ^ pass_sel(m2_y_ff, pass_bytes);
      end else begin
         byte_b = 8'h00;
      end
      mix_byte = byte_a ^ byte_b;
   end

   always_comb begin
      sbank_in = sbank_ff;
      ybank_in = ybank_ff;
      valid_in = valid_ff;
      if (key_load) begin
         valid_in[req_payload.entry_index[SIDX_W-1:0]] = 1'b1;
      end
      if (ctl.mix_end) begin
         sbank_in = ~sbank_ff;
         valid_in = '1;
      end
      if (ctl.comp_end) begin
         ybank_in = ~ybank_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff        <= '0;
         sbank_ff     <= 1'b0;
         ybank_ff     <= 1'b0;
         valid_ff     <= '0;
         m1_v_ff      <= 1'b0;
         m2_v_ff      <= 1'b0;
         c1_v_ff      <= 1'b0;
         c2_v_ff      <= 1'b0;
         c3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index < CSR_LIM)) begin
            pw_ff[csr_index[CSR_WORD_AW-1:0]] <= csr_wdata;
         end
         sbank_ff     <= sbank_in;
         ybank_ff     <= ybank_in;
         valid_ff     <= valid_in;
         m1_v_ff      <= ctl.mix_issue;
         m2_v_ff      <= m1_v_ff;
         c1_v_ff      <= ctl.comp_issue;
         c2_v_ff      <= c1_v_ff;
         c3_v_ff      <= c2_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         data_ff <= req_payload.data_block;
         cnt_ff  <= req_payload.byte_count;
      end
      m1_idx_ff <= ctl.idx;
      m2_idx_ff <= m1_idx_ff;
      m2_y_ff   <= y_rdata;
      m2_okb_ff <= ({1'b0, y_rdata} < SB_LIM);
      m2_va_ff  <= valid_ff[m1_idx_ff[SIDX_W-1:0]];
      m2_vb_ff  <= valid_ff[y_rdata[SIDX_W-1:0]];
      c1_idx_ff <= ctl.idx;
      c2_idx_ff <= c1_idx_ff;
      c3_idx_ff <= c2_idx_ff;
      if (m2_v_ff && ({1'b0, m2_idx_ff} < BLOCK_LIM)) begin
         ks_ff[m2_idx_ff[BLOCK_AW-1:0]] <= mix_byte;
      end
      if (ctl.finish) begin
         rsp_ff.cipher_block <= data_ff ^ ks_ff;
         rsp_ff.valid_bytes  <= cnt_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
